@@ hdl/tosb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package tosb_pkg;

    // Number of channels in the bank (1 to 16).
    localparam int unsigned CHANNELS = 16;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned CHAN_W = 5;

    typedef logic [CHANNELS-1:0] t_lvl;
    typedef logic [TIME_W-1:0] t_time;

    // Request codes carried in the input tuser.
    typedef enum logic [2:0] {
        REQ_TICK       = 3'd0,
        REQ_STEADY_ONE = 3'd1,
        REQ_TEMP_ONE   = 3'd2,
        REQ_STEADY_ALL = 3'd3,
        REQ_TEMP_ALL   = 3'd4,
        REQ_REINIT     = 3'd5
    } t_req;

    // Operation as seen by one cell of the chain.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_TICK,
        OP_STEADY,
        OP_TEMP,
        OP_REINIT
    } t_op;

    // Register indexes of the configuration port.
    localparam logic [0:0] CFG_BUS_MASK = 1'b0;
    localparam logic [0:0] CFG_DEFAULTS = 1'b1;

    // Command broadcast to every cell while a token walks the chain.
    typedef struct packed {
        t_op   op;
        t_time timeout;
        t_time elapsed;
    } t_cmd;

endpackage

`default_nettype wire

@@ hdl/timed_override_signal_bank_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Bank of one-bit status lines, each with a steady level and a temporary
// level that holds while a millisecond countdown runs.
// Input channel (s_axis): tuser carries the request code, tdata carries the
// channel number, the level vector, the timeout and the elapsed time. Every
// accepted item gives exactly one result item on the output channel (m_axis):
// tdata holds the packed levels and tuser the bus update flag.
// Each channel lives in one cell of a chain. After an item is accepted a
// token walks the chain one cell per cycle; each cell updates its own state
// and inserts its level into a vector that travels with the token. The result
// is registered when the token leaves the last cell, and the input stays
// closed until then, so a new item is taken only once the last one is through.
// The output register holds a finished result while the receiver stalls; the
// input is open again meanwhile, and a second result waits in a holding
// register until the first one is taken.
// The configuration port is to be written only while the bank is idle; the
// bank does not enforce this. Synchronous active-low reset clears all levels,
// countdowns, the last sent vector and both configuration registers.
module timed_override_signal_bank_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    // [4:0] channel, [20:5] level_bits, [52:21] timeout, [84:53] elapsed_ms
    input  wire logic [87:0] i_s_axis_tdata,
    // [2:0] req_type
    input  wire logic [2:0]  i_s_axis_tuser,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [15:0] levels
    output logic [15:0]      o_m_axis_tdata,
    // [0] bus_update
    output logic [0:0]       o_m_axis_tuser,
    input  wire logic        i_cfg_we,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import tosb_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_HOLD
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [LEVEL_W-1:0] r_bus_mask;
    logic [LEVEL_W-1:0] r_defaults;

    // Accepted item.
    logic [2:0]         r_req;
    logic [CHAN_W-1:0]  r_chan;
    logic [LEVEL_W-1:0] r_bits;
    t_time              r_timeout;
    t_time              r_elapsed;
    logic               r_start;

    t_lvl               r_last_sent;

    // Output and holding registers.
    logic               r_out_valid;
    t_lvl               r_out_levels;
    logic               r_out_upd;
    t_lvl               r_pend_levels;
    logic               r_pend_upd;

    t_cmd  w_cmd;
    logic  w_single;
    logic  w_exit;
    logic  w_upd;
    logic  w_out_free;
    logic  w_out_load;
    t_lvl  w_lv;
    t_lvl  w_tok;
    t_lvl  w_lvl_chain [CHANNELS];

    // Translate the request code into the cell operation.
    always_comb begin
        w_cmd.timeout = r_timeout;
        w_cmd.elapsed = r_elapsed;
        w_single      = 1'b0;
        case (r_req)
            REQ_TICK: begin
                w_cmd.op = OP_TICK;
            end
            REQ_STEADY_ONE: begin
                w_cmd.op = OP_STEADY;
                w_single = 1'b1;
            end
            REQ_TEMP_ONE: begin
                w_cmd.op = OP_TEMP;
                w_single = 1'b1;
            end
            REQ_STEADY_ALL: begin
                w_cmd.op = OP_STEADY;
            end
            REQ_TEMP_ALL: begin
                w_cmd.op = OP_TEMP;
            end
            REQ_REINIT: begin
                w_cmd.op = OP_REINIT;
            end
            default: begin
                w_cmd.op = OP_NONE;
            end
        endcase
    end

    // The chain of channel cells. Cell 0 receives the start token and an
    // empty level vector; each cell hands both on to its neighbor.
    for (genvar i = 0; i < CHANNELS; i++) begin : g_cell
        logic w_sel;
        logic w_bit;
        logic w_tok_in;
        t_lvl w_lvl_in;

        // Single-channel sets pick one cell and use bit 0; whole-bank sets
        // give every cell its own bit of the vector.
        assign w_sel = w_single ? (r_chan == CHAN_W'(i)) : 1'b1;
        assign w_bit = w_single ? r_bits[0] : r_bits[i];

        if (i == 0) begin : g_head
            assign w_tok_in = r_start;
            assign w_lvl_in = '0;
        end else begin : g_link
            assign w_tok_in = w_tok[i-1];
            assign w_lvl_in = w_lvl_chain[i-1];
        end

        tosb_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_cmd     (w_cmd),
            .i_sel     (w_sel),
            .i_bit     (w_bit),
            .i_default (r_defaults[i]),
            .i_token   (w_tok_in),
            .i_levels  (w_lvl_in),
            .o_token   (w_tok[i]),
            .o_levels  (w_lvl_chain[i])
        );
    end

    assign w_exit     = w_tok[CHANNELS-1];
    assign w_lv       = w_lvl_chain[CHANNELS-1];
    assign w_out_free = !r_out_valid || i_m_axis_tready;

    // The output register loads either a result leaving the chain or the
    // held result, whenever it is empty or being emptied in this cycle.
    assign w_out_load = w_out_free
                        && (((r_state == ST_WALK) && w_exit) || (r_state == ST_HOLD));

    // A tick flags a bus update only when some in-range channel is bus-type
    // and the level vector moved since the last recorded one.
    assign w_upd = (w_cmd.op == OP_TICK) && (r_bus_mask[CHANNELS-1:0] != '0)
                   && (w_lv != r_last_sent);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
            r_bus_mask  <= '0;
            r_defaults  <= '0;
            r_last_sent <= '0;
        end else begin
            r_start <= (r_state == ST_IDLE) && i_s_axis_tvalid;

            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_BUS_MASK: r_bus_mask <= i_cfg_data;
                    CFG_DEFAULTS: r_defaults <= i_cfg_data;
                    default: begin
                    end
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_req     <= i_s_axis_tuser;
                        r_chan    <= i_s_axis_tdata[4:0];
                        r_bits    <= i_s_axis_tdata[20:5];
                        r_timeout <= i_s_axis_tdata[52:21];
                        r_elapsed <= i_s_axis_tdata[84:53];
                        r_state   <= ST_WALK;
                    end
                end
                ST_WALK: begin
                    if (w_exit) begin
                        if (w_cmd.op == OP_TICK && r_bus_mask[CHANNELS-1:0] != '0) begin
                            r_last_sent <= w_lv;
                        end else if (w_cmd.op == OP_REINIT) begin
                            r_last_sent <= '0;
                        end
                        if (w_out_free) begin
                            r_out_levels <= w_lv;
                            r_out_upd    <= w_upd;
                            r_state      <= ST_IDLE;
                        end else begin
                            r_pend_levels <= w_lv;
                            r_pend_upd    <= w_upd;
                            r_state       <= ST_HOLD;
                        end
                    end
                end
                ST_HOLD: begin
                    if (w_out_free) begin
                        r_out_levels <= r_pend_levels;
                        r_out_upd    <= r_pend_upd;
                        r_state      <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = 16'(r_out_levels);
    assign o_m_axis_tuser  = r_out_upd;

`ifndef SYNTHESIS
    // At most one token travels the chain at a time.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_tok, r_start}))
        else $error("more than one token in the cell chain");

    // The input is open only while no token is in flight.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> (w_tok == '0 && !r_start))
        else $error("input open while the chain is busy");

    // The start token reaches the first cell in the cycle after it is raised.
    a_start_hop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |=> w_tok[0])
        else $error("start token did not enter the chain");

    // A held result exists only while the output register is full.
    a_hold_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_HOLD) |-> r_out_valid)
        else $error("holding state with an empty output register");
`endif

endmodule

`default_nettype wire

@@ hdl/tosb_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none

module tosb_cell (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire tosb_pkg::t_cmd  i_cmd,
    input  wire logic            i_sel,
    input  wire logic            i_bit,
    input  wire logic            i_default,
    input  wire logic            i_token,
    input  wire tosb_pkg::t_lvl  i_levels,
    output logic                 o_token,
    output tosb_pkg::t_lvl       o_levels
);
    import tosb_pkg::*;

    logic  r_steady, n_steady;
    logic  r_temp, n_temp;
    logic  r_cur, n_cur;
    t_time r_rem, n_rem;
    logic  r_token;
    t_lvl  r_levels;

    // The cell acts only in the cycle the token sits at its input.
    always_comb begin
        n_steady = r_steady;
        n_temp   = r_temp;
        n_cur    = r_cur;
        n_rem    = r_rem;
        if (i_token) begin
            case (i_cmd.op)
                OP_TICK: begin
                    if (r_rem != '0) begin
                        n_rem = (r_rem >= i_cmd.elapsed) ? r_rem - i_cmd.elapsed : '0;
                        n_cur = r_temp;
                    end else begin
                        n_cur = r_steady;
                    end
                end
                OP_STEADY: begin
                    if (i_sel) begin
                        n_steady = i_bit;
                    end
                end
                OP_TEMP: begin
                    if (i_sel) begin
                        n_temp = i_bit;
                        n_rem  = i_cmd.timeout;
                    end
                end
                OP_REINIT: begin
                    n_steady = i_default;
                    n_temp   = 1'b0;
                    n_rem    = '0;
                    n_cur    = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steady <= 1'b0;
            r_temp   <= 1'b0;
            r_cur    <= 1'b0;
            r_rem    <= '0;
            r_token  <= 1'b0;
            r_levels <= '0;
        end else begin
            r_steady <= n_steady;
            r_temp   <= n_temp;
            r_cur    <= n_cur;
            r_rem    <= n_rem;
            r_token  <= i_token;
            if (i_token) begin
                // Shift the packed vector down and put this cell's level on top.
                r_levels <= (i_levels >> 1) | (t_lvl'(n_cur) << (CHANNELS - 1));
            end
        end
    end

    assign o_token  = r_token;
    assign o_levels = r_levels;

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
    import tosb_pkg::*;

    // Request codes that the package leaves unassigned. The bank must treat
    // them as no-ops that still return one result item.
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    // Mask of the channels that exist in this build of the bank.
    localparam logic [15:0] CHAN_SPAN =
        (CHANNELS >= 16) ? 16'hFFFF : ((16'h0001 << CHANNELS) - 16'h0001);

    // The chain walks one cell per cycle, so the settle time grows with the
    // number of channels.
    localparam int unsigned SETTLE_CYCLES = 2 * CHANNELS + 8;

    // Length of the single long receiver hold-off.
    localparam int unsigned HOLD_CYCLES = 150;

    typedef struct packed {
        logic [2:0]  req;
        logic [4:0]  chan;
        logic [15:0] bits;
        logic [31:0] timeout;
        logic [31:0] elapsed;
    } bank_req_t;

    typedef struct packed {
        logic [15:0] levels;
        logic        bus_update;
    } bank_view_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [87:0] s_data = '0;
    logic [2:0]  s_user = '0;
    logic        m_ready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [0:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;

    logic        o_s_axis_tready;
    logic        o_m_axis_tvalid;
    logic [15:0] o_m_axis_tdata;
    logic [0:0]  o_m_axis_tuser;

    timed_override_signal_bank_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (cfg_we),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Requests waiting to be offered, and the level views that the bank owes
    // for the requests it has already taken.
    bank_req_t  request_q[$];
    bank_view_t owed_views[$];

    int unsigned requests_queued = 0;
    int unsigned requests_taken = 0;
    int unsigned views_seen = 0;
    int unsigned mismatches = 0;

    // Shadow copy of the bank: registers and per-channel state.
    logic [15:0] bus_mask_mirror = '0;
    logic [15:0] defaults_mirror = '0;
    logic        steady_mirror[16];
    logic        temp_mirror[16];
    logic [31:0] remaining_mirror[16];
    logic        shown_mirror[16];
    logic [15:0] last_sent_mirror = '0;

    initial begin
        for (int i = 0; i < 16; i++) begin
            steady_mirror[i] = 1'b0;
            temp_mirror[i] = 1'b0;
            remaining_mirror[i] = '0;
            shown_mirror[i] = 1'b0;
        end
    end

    function automatic logic [15:0] shown_levels();
        logic [15:0] v;
        v = '0;
        for (int i = 0; i < CHANNELS; i++) begin
            v[i] = shown_mirror[i];
        end
        return v;
    endfunction

    // Applies one request to the shadow bank and records the view the bank
    // must return for it.
    task automatic advance_bank(input bank_req_t rq);
        logic [15:0] lv;
        logic        upd;
        upd = 1'b0;
        case (rq.req)
            REQ_TICK: begin
                // A running countdown keeps the temporary level on display,
                // even on the tick that drains it to zero.
                for (int i = 0; i < CHANNELS; i++) begin
                    if (remaining_mirror[i] != '0) begin
                        remaining_mirror[i] = (remaining_mirror[i] >= rq.elapsed) ?
                            remaining_mirror[i] - rq.elapsed : '0;
                        shown_mirror[i] = temp_mirror[i];
                    end else begin
                        shown_mirror[i] = steady_mirror[i];
                    end
                end
                lv = shown_levels();
                // Without any bus channel the last sent vector is left alone.
                if ((bus_mask_mirror & CHAN_SPAN) != '0) begin
                    upd = (lv != last_sent_mirror);
                    last_sent_mirror = lv;
                end
            end
            REQ_STEADY_ONE: begin
                if (rq.chan < CHANNELS) begin
                    steady_mirror[rq.chan] = rq.bits[0];
                end
            end
            REQ_TEMP_ONE: begin
                if (rq.chan < CHANNELS) begin
                    temp_mirror[rq.chan] = rq.bits[0];
                    remaining_mirror[rq.chan] = rq.timeout;
                end
            end
            REQ_STEADY_ALL: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    steady_mirror[i] = rq.bits[i];
                end
            end
            REQ_TEMP_ALL: begin
                for (int i = 0; i < CHANNELS; i++) begin
                    temp_mirror[i] = rq.bits[i];
                    remaining_mirror[i] = rq.timeout;
                end
            end
            REQ_REINIT: begin
                for (int i = 0; i < 16; i++) begin
                    steady_mirror[i] = (i < CHANNELS) ? defaults_mirror[i] : 1'b0;
                    temp_mirror[i] = 1'b0;
                    remaining_mirror[i] = '0;
                    shown_mirror[i] = 1'b0;
                end
                last_sent_mirror = '0;
            end
            default: begin
            end
        endcase
        owed_views.push_back('{levels: shown_levels(), bus_update: upd});
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        $display("%0t: mismatch on %s: expected %h, got %h", $time, what, want, got);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Input side. An item is taken at a rising edge with tvalid and tready
    // both high; the shadow bank advances at that same edge, so the view it
    // predicts sees exactly the register values in force when the item went
    // in. The driver reacts on the falling edge.
    // ------------------------------------------------------------------
    logic      item_taken = 1'b0;
    bank_req_t offered;

    always @(posedge i_clk) begin
        if (i_rst_n && s_valid && o_s_axis_tready) begin
            advance_bank(offered);
            requests_taken++;
            item_taken <= 1'b1;
        end else begin
            item_taken <= 1'b0;
        end
    end

    // The sender offers items in bursts of random length separated by random
    // gaps. Some bursts start with no gap at all, so that back-to-back
    // offers also occur.
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    always @(negedge i_clk) begin
        logic      next_valid;
        bank_req_t next_item;
        next_valid = s_valid;
        next_item = offered;
        if (i_rst_n && (!s_valid || item_taken)) begin
            next_valid = 1'b0;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            end
            if (gap_left > 0) begin
                gap_left--;
            end else if (request_q.size() > 0) begin
                next_item = request_q.pop_front();
                next_valid = 1'b1;
                burst_left--;
            end
        end
        s_valid <= next_valid;
        offered <= next_item;
        s_data <= {3'b000, next_item.elapsed, next_item.timeout, next_item.bits,
                   next_item.chan};
        s_user <= next_item.req;
    end

    // ------------------------------------------------------------------
    // Output side. The receiver steps through stall patterns: always ready,
    // ready at random, ready one cycle in four, and mostly ready at random.
    // Once enough views have come back it holds off for a long stretch while
    // the sender keeps offering, so both output registers fill and the bank
    // has to close its input.
    // ------------------------------------------------------------------
    int unsigned rx_cycle = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    always @(negedge i_clk) begin
        logic ready_now;
        rx_cycle++;
        if (!hold_done && views_seen >= 60) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            ready_now = 1'b0;
        end else begin
            case ((rx_cycle / 64) % 4)
                0: ready_now = 1'b1;
                1: ready_now = ($urandom_range(0, 1) == 1);
                2: ready_now = ((rx_cycle % 4) == 0);
                default: ready_now = ($urandom_range(0, 4) != 0);
            endcase
        end
        m_ready <= ready_now;
    end

    always @(posedge i_clk) begin
        bank_view_t want;
        if (i_rst_n && o_m_axis_tvalid && m_ready) begin
            views_seen++;
            if (owed_views.size() == 0) begin
                report_mismatch("unexpected item", '0, {15'd0, o_m_axis_tuser,
                                o_m_axis_tdata});
            end else begin
                want = owed_views.pop_front();
                if (o_m_axis_tdata !== want.levels) begin
                    report_mismatch("levels", 32'(want.levels), 32'(o_m_axis_tdata));
                end
                if (o_m_axis_tuser[0] !== want.bus_update) begin
                    report_mismatch("bus_update", 32'(want.bus_update),
                                    32'(o_m_axis_tuser[0]));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic queue_request(input logic [2:0] req, input logic [4:0] chan,
                                 input logic [15:0] bits, input logic [31:0] timeout,
                                 input logic [31:0] elapsed);
        request_q.push_back('{req: req, chan: chan, bits: bits, timeout: timeout,
                              elapsed: elapsed});
        requests_queued++;
    endtask

    // Mostly ticks and timed overrides with short countdowns and short
    // elapsed times, so that overrides are seen running, draining and
    // expiring. Full-range values, out-of-range channels, reinitialization
    // and the unused codes are mixed in at a lower rate.
    task automatic queue_random_request();
        int unsigned pick;
        logic [2:0]  req;
        logic [4:0]  chan;
        logic [31:0] timeout;
        logic [31:0] elapsed;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            req = REQ_TICK;
        end else if (pick < 52) begin
            req = REQ_STEADY_ONE;
        end else if (pick < 67) begin
            req = REQ_TEMP_ONE;
        end else if (pick < 75) begin
            req = REQ_STEADY_ALL;
        end else if (pick < 87) begin
            req = REQ_TEMP_ALL;
        end else if (pick < 91) begin
            req = REQ_REINIT;
        end else if (pick < 94) begin
            req = ($urandom_range(0, 1) == 1) ? REQ_SPARE_7 : REQ_SPARE_6;
        end else begin
            req = REQ_TICK;
        end
        chan = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31)) :
               5'($urandom_range(0, CHANNELS - 1));
        pick = $urandom_range(0, 9);
        timeout = (pick == 0) ? 32'd0 : (pick < 8) ? 32'($urandom_range(1, 40)) :
                  32'($urandom);
        pick = $urandom_range(0, 9);
        elapsed = (pick == 0) ? 32'd0 : (pick < 9) ? 32'($urandom_range(1, 15)) :
                  32'($urandom);
        queue_request(req, chan, 16'($urandom), timeout, elapsed);
    endtask

    // The bank is idle once every queued item has been taken and every owed
    // view has come back. The taken counter and the owed views change only at
    // rising edges, so checking at the falling edge is free of races.
    task automatic wait_for_idle();
        while (requests_taken != requests_queued || owed_views.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [0:0] index, input logic [15:0] value);
        @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        if (index == CFG_BUS_MASK) begin
            bus_mask_mirror = value;
        end else begin
            defaults_mirror = value;
        end
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure_bank(input logic [15:0] bus_mask, input logic [15:0] defaults);
        wait_for_idle();
        write_register(CFG_BUS_MASK, bus_mask);
        write_register(CFG_DEFAULTS, defaults);
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        logic [15:0] mask_plan[5];
        logic [15:0] default_plan[5];

        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Pin-only bank: ticks must never flag a bus update.
        configure_bank(16'h0000, 16'h0000);
        queue_request(REQ_TICK, 5'd0, 16'h0000, 32'd0, 32'd0);
        queue_request(REQ_STEADY_ALL, 5'd0, 16'hFFFF, 32'd0, 32'd0);
        queue_request(REQ_TICK, 5'd0, 16'h0000, 32'd0, 32'hFFFF_FFFF);
        // Timed override on one channel: zero elapsed time keeps it running,
        // a huge elapsed time drains it but it still shows on that tick, and
        // the following tick falls back to the steady level.
        queue_request(REQ_TEMP_ONE, 5'd3, 16'hFFFE, 32'd5, 32'd0);
        queue_request(REQ_TICK, 5'd0, 16'h0000, 32'd0, 32'd0);
        queue_request(REQ_TICK, 5'd0, 16'h0000, 32'd0, 32'd2);
        queue_request(REQ_TICK, 5'd0, 16'h0000, 32'd0, 32'hFFFF_FFFF);
        queue_request(REQ_TICK, 5'd0, 16'h0000, 32'd0, 32'd0);
        // Channel numbers past the bank are ignored.
        queue_request(REQ_STEADY_ONE, 5'd31, 16'h0000, 32'd0, 32'd0);
        queue_request(REQ_TEMP_ONE, 5'd16, 16'h0000, 32'hFFFF_FFFF, 32'd0);
        queue_request(REQ_SPARE_6, 5'd31, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        queue_request(REQ_SPARE_7, 5'd0, 16'h0000, 32'd0, 32'd0);
        queue_request(REQ_TICK, 5'd0, 16'h0000, 32'd0, 32'd1);
        queue_request(REQ_STEADY_ONE, 5'd0, 16'hFFFE, 32'd0, 32'd0);
        queue_request(REQ_TICK, 5'd0, 16'h0000, 32'd0, 32'd1);

        // All channels on the bus, with a pattern in the default levels.
        configure_bank(16'hFFFF, 16'hA5A5);
        queue_request(REQ_REINIT, 5'd0, 16'h0000, 32'd0, 32'd0);
        queue_request(REQ_TICK, 5'd0, 16'h0000, 32'd0, 32'd1);
        queue_request(REQ_TICK, 5'd0, 16'h0000, 32'd0, 32'd1);
        queue_request(REQ_TEMP_ALL, 5'd0, 16'h0F0F, 32'hFFFF_FFFF, 32'd0);
        queue_request(REQ_TICK, 5'd0, 16'h0000, 32'd0, 32'd1);
        queue_request(REQ_STEADY_ONE, 5'd15, 16'h0001, 32'd0, 32'd0);
        // A timed override with a zero countdown is not running at all.
        queue_request(REQ_TEMP_ONE, 5'd15, 16'h0000, 32'd0, 32'd0);
        queue_request(REQ_TICK, 5'd0, 16'h0000, 32'd0, 32'hFFFF_FFFF);
        queue_request(REQ_TEMP_ALL, 5'd0, 16'h0000, 32'd0, 32'd0);
        queue_request(REQ_TICK, 5'd0, 16'h0000, 32'd0, 32'd0);

        // Random part, one register setting per phase: single bus channels
        // at both ends, none, all, and random masks.
        mask_plan[0] = 16'h0001;
        default_plan[0] = 16'hFFFF;
        mask_plan[1] = 16'h8000;
        default_plan[1] = 16'h0000;
        mask_plan[2] = 16'($urandom);
        default_plan[2] = 16'($urandom);
        mask_plan[3] = 16'hFFFF;
        default_plan[3] = 16'($urandom);
        mask_plan[4] = 16'h0000;
        default_plan[4] = 16'($urandom);
        for (int p = 0; p < 5; p++) begin
            configure_bank(mask_plan[p], default_plan[p]);
            for (int n = 0; n < 80; n++) begin
                queue_random_request();
            end
        end

        // Any late or surplus item during the settle time is caught by the
        // output checker.
        wait_for_idle();
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // The slowest correct run ends well before this timeout.
    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
